// ===== hdl/pds_pkg.sv =====
// ----------------------------------------------------------------------------
// pds_pkg: shared types and constants for the particle depth sorter
// Field widths, command codes, the stored entry layout and the control
// group that drives the shared arithmetic unit.
// ----------------------------------------------------------------------------
package pds_pkg;

    localparam int POS_W  = 16;   // signed Q8.8 coordinate
    localparam int ATTR_W = 10;   // payload in thousandths
    localparam int KEY_W  = 34;   // exact squared distance
    localparam int CMD_W  = 2;
    localparam int DIFF_W = POS_W + 1;
    localparam int SQ_W   = 2 * POS_W;

    typedef enum logic [CMD_W-1:0] {
        CMD_LOAD  = 2'd0,
        CMD_SORT  = 2'd1,
        CMD_CLEAR = 2'd2
    } cmd_t;

    // axis select for the square-accumulate unit
    localparam logic [1:0] AXIS_X = 2'd0;
    localparam logic [1:0] AXIS_Y = 2'd1;
    localparam logic [1:0] AXIS_Z = 2'd2;

    typedef struct packed {
        logic [POS_W-1:0]  x;
        logic [POS_W-1:0]  y;
        logic [POS_W-1:0]  z;
        logic [ATTR_W-1:0] strength;
        logic [ATTR_W-1:0] seed;
        logic [KEY_W-1:0]  key;
    } entry_t;

    typedef struct packed {
        logic       sq_en;      // register a new square
        logic       acc_en;     // fold registered square into accumulator
        logic       acc_first;  // start a fresh sum
        logic [1:0] axis;
    } arith_ctl_t;

endpackage

// ===== hdl/pds_in_if.sv =====
// ----------------------------------------------------------------------------
// pds_in_if: command channel of the particle depth sorter
// Valid/ready channel carrying one command with particle and camera fields.
// ----------------------------------------------------------------------------
interface pds_in_if import pds_pkg::*;
    ;
    logic                     valid;
    logic                     ready;
    logic [CMD_W-1:0]         cmd;
    logic signed [POS_W-1:0]  particle_x;
    logic signed [POS_W-1:0]  particle_y;
    logic signed [POS_W-1:0]  particle_z;
    logic [ATTR_W-1:0]        particle_strength;
    logic [ATTR_W-1:0]        particle_seed;
    logic signed [POS_W-1:0]  camera_x;
    logic signed [POS_W-1:0]  camera_y;
    logic signed [POS_W-1:0]  camera_z;

    modport source (
        output valid, cmd, particle_x, particle_y, particle_z,
               particle_strength, particle_seed, camera_x, camera_y, camera_z,
        input  ready
    );

    modport sink (
        input  valid, cmd, particle_x, particle_y, particle_z,
               particle_strength, particle_seed, camera_x, camera_y, camera_z,
        output ready
    );
endinterface

// ===== hdl/pds_out_if.sv =====
// ----------------------------------------------------------------------------
// pds_out_if: result channel of the particle depth sorter
// Valid/ready channel carrying one sorted particle with its distance.
// ----------------------------------------------------------------------------
interface pds_out_if import pds_pkg::*;
    ;
    logic                     valid;
    logic                     ready;
    logic signed [POS_W-1:0]  out_x;
    logic signed [POS_W-1:0]  out_y;
    logic signed [POS_W-1:0]  out_z;
    logic [ATTR_W-1:0]        out_strength;
    logic [ATTR_W-1:0]        out_seed;
    logic [KEY_W-1:0]         distance_sq;
    logic                     last;

    modport source (
        output valid, out_x, out_y, out_z, out_strength, out_seed,
               distance_sq, last,
        input  ready
    );

    modport sink (
        input  valid, out_x, out_y, out_z, out_strength, out_seed,
               distance_sq, last,
        output ready
    );
endinterface

// ===== hdl/particle_depth_sorter.sv =====
// ----------------------------------------------------------------------------
// particle_depth_sorter: sort stored particles by squared camera distance
// Loads, clears and sorts a particle store and streams the sorted run.
// ----------------------------------------------------------------------------
// A load transfer appends one particle (ignored when MAX_PARTICLES are held)
// and a clear transfer empties the store; neither leaves the idle state, so
// loads can stream back to back. A sort transfer latches the camera and holds
// the block busy (in_ch.ready low) until the last result has been taken. Each
// stored particle gets its key in steps: one memory read, three squares
// through the single shared 16x16 multiplier plus one drain step, one write
// back. The stable insertion sort then runs on the entry memory, which has one
// read port and one write port. Each result is read, loaded into the output
// register and offered; the next is read only after it has been taken, and
// the final one carries last. An empty store returns no results and the block
// stays ready.
// ----------------------------------------------------------------------------
module particle_depth_sorter import pds_pkg::*;
#(
    parameter int MAX_PARTICLES = 64
)
(
    input  logic       clk,
    input  logic       rst_n,
    pds_in_if.sink     in_ch,
    pds_out_if.source  out_ch
);

    localparam int IDX_W = $clog2(MAX_PARTICLES);
    localparam int CNT_W = $clog2(MAX_PARTICLES + 1);

    typedef enum logic [11:0] {
        ST_IDLE   = 12'b0000_0000_0001,
        ST_K_RD   = 12'b0000_0000_0010,   // read entry for key
        ST_K_SQ   = 12'b0000_0000_0100,   // square-accumulate steps
        ST_K_WR   = 12'b0000_0000_1000,   // write key back
        ST_S_RDI  = 12'b0000_0001_0000,   // read element i
        ST_S_HOLD = 12'b0000_0010_0000,   // capture element i
        ST_S_RDJ  = 12'b0000_0100_0000,   // read element j-1
        ST_S_CMP  = 12'b0000_1000_0000,   // compare, shift up
        ST_S_PUT  = 12'b0001_0000_0000,   // drop held element at j
        ST_E_RD   = 12'b0010_0000_0000,   // read result entry
        ST_E_LOAD = 12'b0100_0000_0000,   // fill output register
        ST_E_WAIT = 12'b1000_0000_0000    // wait for output transfer
    } state_t;

    state_t           state_reg, state_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic [CNT_W-1:0] i_reg, i_next;
    logic [CNT_W-1:0] j_reg, j_next;
    logic [1:0]       step_reg, step_next;
    logic             out_valid_reg, out_valid_next;

    // payload registers
    logic [POS_W-1:0] cam_x_reg, cam_y_reg, cam_z_reg;
    entry_t           hold_reg;
    entry_t           out_entry_reg;
    logic             out_last_reg;

    logic [CNT_W-1:0] i_inc;
    logic [CNT_W-1:0] j_dec;
    logic             i_is_last;
    logic             in_xfer;
    logic             out_xfer;
    cmd_t             cmd;

    // memory ports
    logic             wr_en;
    logic [IDX_W-1:0] wr_addr;
    entry_t           wr_data;
    logic             rd_en;
    logic [IDX_W-1:0] rd_addr;
    entry_t           rd_data;

    arith_ctl_t       arith_ctl;
    logic [KEY_W-1:0] acc;
    logic             key_gt;
    entry_t           load_entry;

    assign in_xfer   = in_ch.valid && in_ch.ready;
    assign out_xfer  = out_ch.valid && out_ch.ready;
    assign cmd       = cmd_t'(in_ch.cmd);
    assign i_inc     = i_reg + CNT_W'(1);
    assign j_dec     = j_reg - CNT_W'(1);
    assign i_is_last = (i_inc == count_reg);

    assign in_ch.ready = (state_reg == ST_IDLE);

    always_comb
    begin
        load_entry          = '0;
        load_entry.x        = in_ch.particle_x;
        load_entry.y        = in_ch.particle_y;
        load_entry.z        = in_ch.particle_z;
        load_entry.strength = in_ch.particle_strength;
        load_entry.seed     = in_ch.particle_seed;
    end

    // sequencer
    always_comb
    begin
        state_next     = state_reg;
        count_next     = count_reg;
        i_next         = i_reg;
        j_next         = j_reg;
        step_next      = step_reg;
        out_valid_next = out_valid_reg;

        wr_en   = 1'b0;
        wr_addr = i_reg[IDX_W-1:0];
        wr_data = rd_data;
        rd_en   = 1'b0;
        rd_addr = i_reg[IDX_W-1:0];

        arith_ctl           = '0;
        arith_ctl.axis      = step_reg;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_xfer)
                begin
                    unique case (cmd)
                        CMD_LOAD:
                        begin
                            if (count_reg < CNT_W'(MAX_PARTICLES))
                            begin
                                wr_en      = 1'b1;
                                wr_addr    = count_reg[IDX_W-1:0];
                                wr_data    = load_entry;
                                count_next = count_reg + CNT_W'(1);
                            end
                        end
                        CMD_CLEAR:
                        begin
                            count_next = '0;
                        end
                        CMD_SORT:
                        begin
                            if (count_reg != '0)
                            begin
                                i_next     = '0;
                                state_next = ST_K_RD;
                            end
                        end
                        default:
                        begin
                        end
                    endcase
                end
            end

            ST_K_RD:
            begin
                rd_en      = 1'b1;
                step_next  = '0;
                state_next = ST_K_SQ;
            end

            // steps 0..2 square x, y, z; steps 1..3 accumulate
            ST_K_SQ:
            begin
                arith_ctl.sq_en     = (step_reg != 2'd3);
                arith_ctl.acc_en    = (step_reg != 2'd0);
                arith_ctl.acc_first = (step_reg == 2'd1);
                step_next           = step_reg + 2'd1;
                if (step_reg == 2'd3)
                begin
                    state_next = ST_K_WR;
                end
            end

            ST_K_WR:
            begin
                wr_en       = 1'b1;
                wr_data     = rd_data;
                wr_data.key = acc;
                if (i_is_last)
                begin
                    if (count_reg == CNT_W'(1))
                    begin
                        i_next     = '0;
                        state_next = ST_E_RD;
                    end
                    else
                    begin
                        i_next     = CNT_W'(1);
                        state_next = ST_S_RDI;
                    end
                end
                else
                begin
                    i_next     = i_inc;
                    state_next = ST_K_RD;
                end
            end

            ST_S_RDI:
            begin
                rd_en      = 1'b1;
                state_next = ST_S_HOLD;
            end

            ST_S_HOLD:
            begin
                j_next     = i_reg;
                state_next = ST_S_RDJ;
            end

            ST_S_RDJ:
            begin
                if (j_reg == '0)
                begin
                    state_next = ST_S_PUT;
                end
                else
                begin
                    rd_en      = 1'b1;
                    rd_addr    = j_dec[IDX_W-1:0];
                    state_next = ST_S_CMP;
                end
            end

            // strict compare keeps equal keys in their old order
            ST_S_CMP:
            begin
                if (key_gt)
                begin
                    wr_en      = 1'b1;
                    wr_addr    = j_reg[IDX_W-1:0];
                    wr_data    = rd_data;
                    j_next     = j_dec;
                    state_next = ST_S_RDJ;
                end
                else
                begin
                    state_next = ST_S_PUT;
                end
            end

            ST_S_PUT:
            begin
                wr_en   = 1'b1;
                wr_addr = j_reg[IDX_W-1:0];
                wr_data = hold_reg;
                if (i_is_last)
                begin
                    i_next     = '0;
                    state_next = ST_E_RD;
                end
                else
                begin
                    i_next     = i_inc;
                    state_next = ST_S_RDI;
                end
            end

            ST_E_RD:
            begin
                rd_en      = 1'b1;
                state_next = ST_E_LOAD;
            end

            ST_E_LOAD:
            begin
                out_valid_next = 1'b1;
                state_next     = ST_E_WAIT;
            end

            ST_E_WAIT:
            begin
                if (out_xfer)
                begin
                    out_valid_next = 1'b0;
                    if (out_last_reg)
                    begin
                        state_next = ST_IDLE;
                    end
                    else
                    begin
                        i_next     = i_inc;
                        state_next = ST_E_RD;
                    end
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            count_reg     <= '0;
            i_reg         <= '0;
            j_reg         <= '0;
            step_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            i_reg         <= i_next;
            j_reg         <= j_next;
            step_reg      <= step_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // payload: camera on sort transfer, held element, output register
    always_ff @(posedge clk)
    begin
        if (in_xfer && (cmd == CMD_SORT))
        begin
            cam_x_reg <= in_ch.camera_x;
            cam_y_reg <= in_ch.camera_y;
            cam_z_reg <= in_ch.camera_z;
        end
        if (state_reg == ST_S_HOLD)
        begin
            hold_reg <= rd_data;
        end
        if (state_reg == ST_E_LOAD)
        begin
            out_entry_reg <= rd_data;
            out_last_reg  <= i_is_last;
        end
    end

    pds_store #(
        .DEPTH (MAX_PARTICLES)
    ) u_store (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    pds_arith u_arith (
        .clk    (clk),
        .rst_n  (rst_n),
        .ctl    (arith_ctl),
        .point  (rd_data),
        .cam_x  (cam_x_reg),
        .cam_y  (cam_y_reg),
        .cam_z  (cam_z_reg),
        .key_a  (rd_data.key),
        .key_b  (hold_reg.key),
        .acc    (acc),
        .key_gt (key_gt)
    );

    assign out_ch.valid        = out_valid_reg;
    assign out_ch.out_x        = out_entry_reg.x;
    assign out_ch.out_y        = out_entry_reg.y;
    assign out_ch.out_z        = out_entry_reg.z;
    assign out_ch.out_strength = out_entry_reg.strength;
    assign out_ch.out_seed     = out_entry_reg.seed;
    assign out_ch.distance_sq  = out_entry_reg.key;
    assign out_ch.last         = out_last_reg;

endmodule

// ===== hdl/pds_arith.sv =====
// ----------------------------------------------------------------------------
// pds_arith: shared square-accumulate and key compare unit
// Squares one coordinate difference per cycle, while sq_en is set, into a
// product register and folds it into a 34-bit sum; also compares two sort keys.
// ----------------------------------------------------------------------------
module pds_arith import pds_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  arith_ctl_t       ctl,
    input  entry_t           point,
    input  logic [POS_W-1:0] cam_x,
    input  logic [POS_W-1:0] cam_y,
    input  logic [POS_W-1:0] cam_z,
    input  logic [KEY_W-1:0] key_a,
    input  logic [KEY_W-1:0] key_b,
    output logic [KEY_W-1:0] acc,
    output logic             key_gt
);

    logic [POS_W-1:0]  p_sel;
    logic [POS_W-1:0]  c_sel;
    logic [DIFF_W-1:0] diff;
    logic [DIFF_W-1:0] mag;
    logic [SQ_W-1:0]   prod_reg;
    logic [KEY_W-1:0]  acc_reg;

    always_comb
    begin
        unique case (ctl.axis)
            AXIS_Y:
            begin
                p_sel = point.y;
                c_sel = cam_y;
            end
            AXIS_Z:
            begin
                p_sel = point.z;
                c_sel = cam_z;
            end
            default:
            begin
                p_sel = point.x;
                c_sel = cam_x;
            end
        endcase
    end

    // 17-bit difference; magnitude never exceeds 65535
    assign diff = {p_sel[POS_W-1], p_sel} - {c_sel[POS_W-1], c_sel};
    assign mag  = diff[DIFF_W-1] ? (~diff + DIFF_W'(1)) : diff;

    always_ff @(posedge clk)
    begin
        if (ctl.sq_en)
        begin
            prod_reg <= mag[POS_W-1:0] * mag[POS_W-1:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            acc_reg <= '0;
        end
        else if (ctl.acc_en)
        begin
            if (ctl.acc_first)
            begin
                acc_reg <= KEY_W'(prod_reg);
            end
            else
            begin
                acc_reg <= acc_reg + KEY_W'(prod_reg);
            end
        end
    end

    assign acc    = acc_reg;
    assign key_gt = key_a > key_b;

endmodule

// ===== hdl/pds_store.sv =====
// ----------------------------------------------------------------------------
// pds_store: particle entry memory
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module pds_store import pds_pkg::*;
#(
    parameter int DEPTH = 64
)
(
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  entry_t                   wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output entry_t                   rd_data
);

    entry_t mem [DEPTH];
    entry_t rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

// ===== sim/particle_sort_checker.sv =====
// ----------------------------------------------------------------------------
// particle_sort_checker: result checker for the particle depth sorter
// Watches both channels, keeps its own copy of the particle store, ranks it
// by squared camera distance on every sort transfer and compares each result
// transfer with the oldest ranked particle still owed.
// ----------------------------------------------------------------------------
module particle_sort_checker import pds_pkg::*;
#(
    parameter int CAPACITY = 64
)
(
    input  logic        clk,
    input  logic        rst_n,
    pds_in_if           cmd_mon,
    pds_out_if          res_mon,
    output int unsigned mismatches,
    output int unsigned pending_results
);

    typedef struct packed {
        entry_t part;
        logic   last;
    } ranked_t;

    entry_t      held [CAPACITY];
    int unsigned held_n = 0;
    ranked_t     ranked_q [$];

    initial mismatches = 0;
    initial pending_results = 0;

    function automatic logic [KEY_W-1:0] squared_distance(
        input entry_t                  p,
        input logic signed [POS_W-1:0] cx,
        input logic signed [POS_W-1:0] cy,
        input logic signed [POS_W-1:0] cz
    );
        longint dx;
        longint dy;
        longint dz;
        dx = longint'($signed(p.x)) - longint'(cx);
        dy = longint'($signed(p.y)) - longint'(cy);
        dz = longint'($signed(p.z)) - longint'(cz);
        return KEY_W'(dx * dx + dy * dy + dz * dz);
    endfunction

    // stable insertion sort, ascending; store keeps the sorted order
    task automatic rank_by_distance(
        input logic signed [POS_W-1:0] cx,
        input logic signed [POS_W-1:0] cy,
        input logic signed [POS_W-1:0] cz
    );
        entry_t  moving;
        ranked_t r;
        int      j;
        for (int i = 0; i < int'(held_n); i++)
            held[i].key = squared_distance(held[i], cx, cy, cz);
        for (int i = 1; i < int'(held_n); i++)
        begin
            moving = held[i];
            j = i;
            while (j > 0 && held[j-1].key > moving.key)
            begin
                held[j] = held[j-1];
                j--;
            end
            held[j] = moving;
        end
        for (int i = 0; i < int'(held_n); i++)
        begin
            r.part = held[i];
            r.last = (i == int'(held_n) - 1);
            ranked_q.push_back(r);
        end
    endtask

    task automatic compare_field(
        input string              name,
        input logic signed [63:0] want,
        input logic signed [63:0] got
    );
        if (want !== got)
        begin
            $error("%s: expected %0d, got %0d", name, want, got);
            mismatches++;
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        ranked_t want;
        if (!rst_n)
        begin
            held_n = 0;
            ranked_q.delete();
            pending_results <= 0;
        end
        else
        begin
            if (res_mon.valid && res_mon.ready)
            begin
                if (ranked_q.size() == 0)
                begin
                    $error("result transfer with nothing owed: x %0d dist %0d",
                           res_mon.out_x, res_mon.distance_sq);
                    mismatches++;
                end
                else
                begin
                    want = ranked_q.pop_front();
                    compare_field("out_x", $signed(want.part.x), res_mon.out_x);
                    compare_field("out_y", $signed(want.part.y), res_mon.out_y);
                    compare_field("out_z", $signed(want.part.z), res_mon.out_z);
                    compare_field("out_strength", want.part.strength,
                                  res_mon.out_strength);
                    compare_field("out_seed", want.part.seed, res_mon.out_seed);
                    compare_field("distance_sq", want.part.key, res_mon.distance_sq);
                    compare_field("last", want.last, res_mon.last);
                end
            end
            if (cmd_mon.valid && cmd_mon.ready)
            begin
                case (cmd_mon.cmd)
                    CMD_LOAD:
                    begin
                        if (held_n < CAPACITY)
                        begin
                            held[held_n].x        = cmd_mon.particle_x;
                            held[held_n].y        = cmd_mon.particle_y;
                            held[held_n].z        = cmd_mon.particle_z;
                            held[held_n].strength = cmd_mon.particle_strength;
                            held[held_n].seed     = cmd_mon.particle_seed;
                            held[held_n].key      = '0;
                            held_n++;
                        end
                    end
                    CMD_SORT:
                        rank_by_distance(cmd_mon.camera_x, cmd_mon.camera_y,
                                         cmd_mon.camera_z);
                    CMD_CLEAR:
                        held_n = 0;
                    default: ;
                endcase
            end
            pending_results <= ranked_q.size();
        end
    end

endmodule

// ===== sim/tb_particle_depth_sorter.sv =====
// ----------------------------------------------------------------------------
// tb_particle_depth_sorter: testbench for the particle depth sorter
// Drives load, clear and sort transfers with random source and sink idling;
// the checker beside the block predicts every sorted run and compares it.
// ----------------------------------------------------------------------------
module tb_particle_depth_sorter;
    import pds_pkg::*;

    localparam int CAPACITY         = 64;
    localparam int RANDOM_ITEMS     = 370;
    localparam int SINK_HOLD_CYCLES = 400;
    localparam int DRAIN_CYCLES     = 50;
    // leaves room for every transfer being a full 64-entry reversed sort
    // with its 64 results
    localparam int CYCLE_LIMIT      = 20_000_000;

    // command code the block must ignore
    localparam logic [CMD_W-1:0] CMD_UNUSED = 2'd3;

    // coordinate styles for random particles and cameras
    localparam int STYLE_FULL    = 0;   // any 16-bit value
    localparam int STYLE_GRID    = 1;   // -1.0, 0, +1.0: many equal distances
    localparam int STYLE_EXTREME = 2;   // range ends and the values around zero

    logic        clk = 1'b0;
    logic        rst_n;
    int unsigned mismatches;
    int unsigned pending_results;
    int unsigned cycle_count = 0;

    // idling percentages; the sink value crosses into the sink process
    int          source_idle_pct = 30;
    int          sink_idle_pct = 70;
    logic        sink_hold_req = 1'b0;

    // stimulus bookkeeping: particles the store should hold, and items that
    // the block actually acts on (ignored ones are not counted)
    int unsigned held = 0;
    int unsigned acted_items = 0;

    pds_in_if  cmd_ch ();
    pds_out_if res_ch ();

    particle_depth_sorter #(
        .MAX_PARTICLES (CAPACITY)
    ) dut (
        .clk    (clk),
        .rst_n  (rst_n),
        .in_ch  (cmd_ch),
        .out_ch (res_ch)
    );

    particle_sort_checker #(
        .CAPACITY (CAPACITY)
    ) sort_check (
        .clk             (clk),
        .rst_n           (rst_n),
        .cmd_mon         (cmd_ch),
        .res_mon         (res_ch),
        .mismatches      (mismatches),
        .pending_results (pending_results)
    );

    always
    begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    // runaway guard
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT)
        begin
            $display("tb_particle_depth_sorter failed");
            $finish;
        end
    end

    // Sink side. Ready is redrawn every cycle from the current idle rate.
    // A hold request from the stimulus drops ready for a long counted
    // stretch, so a sort run backs up and the command channel stalls.
    initial
    begin
        int unsigned hold_left;
        logic        hold_taken;
        hold_left  = 0;
        hold_taken = 1'b0;
        res_ch.ready <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (sink_hold_req && !hold_taken)
            begin
                hold_taken = 1'b1;
                hold_left  = SINK_HOLD_CYCLES;
            end
            if (hold_left != 0)
            begin
                hold_left--;
                res_ch.ready <= 1'b0;
            end
            else
                res_ch.ready <= ($urandom_range(0, 99) >= sink_idle_pct);
        end
    end

    // phase 0: source idles 30%, sink 70%; phase 1 swapped; phase 2 none
    task automatic set_idle_phase(input int phase);
        case (phase)
            0:
            begin
                source_idle_pct = 30;
                sink_idle_pct <= 70;
            end
            1:
            begin
                source_idle_pct = 70;
                sink_idle_pct <= 30;
            end
            default:
            begin
                source_idle_pct = 0;
                sink_idle_pct <= 0;
            end
        endcase
    endtask

    // One command transfer. Called at a rising edge; returns at the edge
    // that takes the transfer. Valid gets one assignment per edge only.
    task automatic send_command(
        input logic [CMD_W-1:0]  cmd,
        input logic [POS_W-1:0]  px,
        input logic [POS_W-1:0]  py,
        input logic [POS_W-1:0]  pz,
        input logic [ATTR_W-1:0] ps,
        input logic [ATTR_W-1:0] pe,
        input logic [POS_W-1:0]  cx,
        input logic [POS_W-1:0]  cy,
        input logic [POS_W-1:0]  cz
    );
        int unsigned gap;
        if ($urandom_range(0, 99) < source_idle_pct)
        begin
            gap = $urandom_range(1, 4);
            cmd_ch.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        cmd_ch.valid             <= 1'b1;
        cmd_ch.cmd               <= cmd;
        cmd_ch.particle_x        <= px;
        cmd_ch.particle_y        <= py;
        cmd_ch.particle_z        <= pz;
        cmd_ch.particle_strength <= ps;
        cmd_ch.particle_seed     <= pe;
        cmd_ch.camera_x          <= cx;
        cmd_ch.camera_y          <= cy;
        cmd_ch.camera_z          <= cz;
        do
            @(posedge clk);
        while (!cmd_ch.ready);
    endtask

    function automatic logic [POS_W-1:0] random_coord(input int style);
        case (style)
            STYLE_GRID:
                case ($urandom_range(0, 2))
                    0:       return -16'sd256;
                    1:       return 16'sd0;
                    default: return 16'sd256;
                endcase
            STYLE_EXTREME:
                case ($urandom_range(0, 3))
                    0:       return 16'h8000;
                    1:       return 16'hFFFF;
                    2:       return 16'h0000;
                    default: return 16'h7FFF;
                endcase
            default:
                return POS_W'($urandom_range(0, 65535));
        endcase
    endfunction

    function automatic int random_style();
        if ($urandom_range(0, 99) < 60)
            return STYLE_FULL;
        return $urandom_range(STYLE_GRID, STYLE_EXTREME);
    endfunction

    // camera fields are don't-care on a load; keep them random anyway
    task automatic load_particle(
        input logic [POS_W-1:0]  x,
        input logic [POS_W-1:0]  y,
        input logic [POS_W-1:0]  z,
        input logic [ATTR_W-1:0] strength,
        input logic [ATTR_W-1:0] seed
    );
        if (held < CAPACITY)
        begin
            held++;
            acted_items++;
        end
        send_command(CMD_LOAD, x, y, z, strength, seed,
                     random_coord(STYLE_FULL), random_coord(STYLE_FULL),
                     random_coord(STYLE_FULL));
    endtask

    task automatic load_random_particle(input int style);
        load_particle(random_coord(style), random_coord(style), random_coord(style),
                      ATTR_W'($urandom_range(0, 999)), ATTR_W'($urandom_range(0, 999)));
    endtask

    // particle fields are don't-care on a sort
    task automatic sort_store(
        input logic [POS_W-1:0] cx,
        input logic [POS_W-1:0] cy,
        input logic [POS_W-1:0] cz
    );
        acted_items++;
        send_command(CMD_SORT, random_coord(STYLE_FULL), random_coord(STYLE_FULL),
                     random_coord(STYLE_FULL), ATTR_W'($urandom_range(0, 1023)),
                     ATTR_W'($urandom_range(0, 1023)), cx, cy, cz);
    endtask

    task automatic sort_random_camera();
        int style;
        style = random_style();
        sort_store(random_coord(style), random_coord(style), random_coord(style));
    endtask

    task automatic clear_store();
        held = 0;
        acted_items++;
        send_command(CMD_CLEAR, random_coord(STYLE_FULL), random_coord(STYLE_FULL),
                     random_coord(STYLE_FULL), ATTR_W'($urandom_range(0, 1023)),
                     ATTR_W'($urandom_range(0, 1023)), random_coord(STYLE_FULL),
                     random_coord(STYLE_FULL), random_coord(STYLE_FULL));
    endtask

    // unused command code with random fields: must change nothing
    task automatic send_unused();
        send_command(CMD_UNUSED, random_coord(STYLE_FULL), random_coord(STYLE_FULL),
                     random_coord(STYLE_FULL), ATTR_W'($urandom_range(0, 1023)),
                     ATTR_W'($urandom_range(0, 1023)), random_coord(STYLE_FULL),
                     random_coord(STYLE_FULL), random_coord(STYLE_FULL));
    endtask

    // source pause: stop offering until every owed result has been taken
    task automatic wait_for_results();
        cmd_ch.valid <= 1'b0;
        @(posedge clk);
        while (pending_results != 0)
            @(posedge clk);
    endtask

    initial
    begin
        int pick;
        int style;
        int count;
        int wf_seq;
        rst_n <= 1'b0;
        cmd_ch.valid             <= 1'b0;
        cmd_ch.cmd               <= CMD_LOAD;
        cmd_ch.particle_x        <= '0;
        cmd_ch.particle_y        <= '0;
        cmd_ch.particle_z        <= '0;
        cmd_ch.particle_strength <= '0;
        cmd_ch.particle_seed     <= '0;
        cmd_ch.camera_x          <= '0;
        cmd_ch.camera_y          <= '0;
        cmd_ch.camera_z          <= '0;
        wf_seq = 0;
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // ---------------- directed part ----------------
        set_idle_phase(0);
        // sort right after reset: empty store, no results
        sort_store(16'h0000, 16'h0000, 16'h0000);
        send_unused();
        // coordinate and payload extremes
        load_particle(16'h7FFF, 16'h8000, 16'h0000, 10'd999, 10'd0);
        load_particle(16'h8000, 16'h7FFF, 16'hFFFF, 10'd0, 10'd999);
        load_particle(16'h0000, 16'h0000, 16'h0000, 10'd512, 10'd511);
        // same spot as the previous one: equal distance, order must hold
        load_particle(16'h0000, 16'h0000, 16'h0000, 10'd1, 10'd2);
        load_particle(16'h7FFF, 16'h7FFF, 16'h7FFF, 10'd700, 10'd300);
        // farthest corner: largest possible distance on the last particle
        sort_store(16'h8000, 16'h8000, 16'h8000);
        // camera at origin: one pair of ties
        sort_store(16'h0000, 16'h0000, 16'h0000);
        wait_for_results();

        // long sink hold while the source keeps offering: the block sits
        // on a full run and the loads back up at its input
        sink_hold_req <= 1'b1;
        sort_store(16'h0100, 16'hFF00, 16'h0080);
        repeat (4) load_random_particle(STYLE_FULL);
        sort_random_camera();

        clear_store();
        sort_store(16'h7FFF, 16'h7FFF, 16'h7FFF);     // emptied store
        load_random_particle(STYLE_EXTREME);
        sort_random_camera();                         // single particle, last set

        // ---------------- random part ----------------
        acted_items = 0;
        while (acted_items < RANDOM_ITEMS)
        begin
            set_idle_phase(acted_items * 3 / RANDOM_ITEMS);
            pick = $urandom_range(0, 99);
            if (pick < 8)
                clear_store();
            else if (pick < 12)
                send_unused();
            else if (pick < 18)
                sort_random_camera();
            else
            begin
                // well-formed run: fresh or appended loads, then sorts
                wf_seq++;
                if ($urandom_range(0, 1))
                    clear_store();
                style = random_style();
                if (wf_seq == 6 || wf_seq == 30)
                    count = $urandom_range(CAPACITY + 2, CAPACITY + 8);   // overfill
                else if ($urandom_range(0, 9) == 0)
                    count = $urandom_range(9, 24);
                else
                    count = $urandom_range(1, 8);
                repeat (count) load_random_particle(style);
                repeat ($urandom_range(1, 2)) sort_random_camera();
                if ($urandom_range(0, 3) == 0)
                begin
                    // append to an already sorted store and sort again
                    repeat ($urandom_range(1, 3)) load_random_particle(style);
                    sort_random_camera();
                end
            end
        end

        // ---------------- drain ----------------
        wait_for_results();
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (mismatches == 0 && pending_results == 0)
            $display("tb_particle_depth_sorter passed");
        else
            $display("tb_particle_depth_sorter failed");
        $finish;
    end

endmodule

// ===== sim.f =====
hdl/pds_pkg.sv
hdl/pds_in_if.sv
hdl/pds_out_if.sv
hdl/pds_arith.sv
hdl/pds_store.sv
hdl/particle_depth_sorter.sv
sim/particle_sort_checker.sv
sim/tb_particle_depth_sorter.sv
